[rtl/fms_pkg.sv]
// Shared types, codes and constants of the follower mission supervisor.
// Used by fms_decide and follower_mission_supervisor; depends on nothing else.
package fms_pkg;

  // Stream and configuration widths.
  localparam int S_TDATA_W = 216;
  localparam int M_TDATA_W = 8;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W = 16;

  // Covariance trace above 8.0 in Q8.8 means the estimate is unusable.
  localparam logic [15:0] COV_LIMIT = 16'd2048;

  // Register defaults after reset.
  localparam logic [15:0] RST_LOST_HOLD_MS = 16'd1000;
  localparam logic [15:0] RST_LANDING_ALT_LIMIT = 16'd128;
  localparam logic [15:0] RST_LANDING_VZ_LIMIT = 16'd51;
  localparam logic [14:0] RST_LANDING_HSPEED_LIMIT = 15'd77;
  localparam logic [15:0] RST_LANDING_CONFIRM_MS = 16'd2000;
  localparam logic [14:0] RST_START_SPEED_LIMIT = 15'd128;
  localparam logic [15:0] RST_START_CONFIRM_MS = 16'd1000;
  localparam logic [14:0] RST_HOVER_SPEED_LIMIT = 15'd51;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LOST_HOLD_MS         = 8'd0,
    REG_LANDING_ALT_LIMIT    = 8'd1,
    REG_LANDING_VZ_LIMIT     = 8'd2,
    REG_LANDING_HSPEED_LIMIT = 8'd3,
    REG_LANDING_CONFIRM_MS   = 8'd4,
    REG_START_SPEED_LIMIT    = 8'd5,
    REG_START_CONFIRM_MS     = 8'd6,
    REG_HOVER_SPEED_LIMIT    = 8'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_WAIT     = 3'd0,
    ST_READY    = 3'd1,
    ST_FOLLOW   = 3'd2,
    ST_HOVER    = 3'd3,
    ST_LANDCAND = 3'd4,
    ST_LANDED   = 3'd5,
    ST_LOST     = 3'd6,
    ST_FAILSAFE = 3'd7
  } mission_t;

  typedef enum logic [2:0] {
    MODE_HOVER         = 3'd0,
    MODE_FOLLOW        = 3'd1,
    MODE_HOVER_TRACK   = 3'd2,
    MODE_HOVER_CONFIRM = 3'd3,
    MODE_LAND          = 3'd4,
    MODE_HOLD          = 3'd5,
    MODE_FAILSAFE_LAND = 3'd6
  } mode_t;

  // Mission state and timers carried from one update to the next.
  typedef struct packed {
    mission_t    mission;
    logic        seen_once;
    logic [31:0] last_seen_time;
    logic        start_pending;
    logic [31:0] start_time;
    logic        landing_pending;
    logic [31:0] landing_time;
    logic        followed_once;
  } fms_state_t;

  // Thresholds as the decision logic uses them; speed limits are squared.
  typedef struct packed {
    logic [15:0]        lost_hold_ms;
    logic signed [15:0] landing_alt_limit;
    logic signed [15:0] landing_vz_limit;
    logic [29:0]        landing_hs_sq;
    logic [15:0]        landing_confirm_ms;
    logic [29:0]        start_sq;
    logic [15:0]        start_confirm_ms;
    logic [29:0]        hover_sq;
  } fms_cfg_t;

  // One update after the squaring stage.
  typedef struct packed {
    logic [31:0]        now_ms;
    logic               sighted;
    logic               alt_valid;
    logic signed [15:0] altitude;
    logic               cov_over;
    logic signed [15:0] vz;
    logic [31:0]        sq_x;
    logic [31:0]        sq_y;
  } fms_item_t;

  // Control policy that belongs to each mission state.
  function automatic mode_t mode_of(mission_t s);
    mode_t m;
    case (s)
      ST_WAIT:     m = MODE_HOVER;
      ST_READY:    m = MODE_HOVER;
      ST_FOLLOW:   m = MODE_FOLLOW;
      ST_HOVER:    m = MODE_HOVER_TRACK;
      ST_LANDCAND: m = MODE_HOVER_CONFIRM;
      ST_LANDED:   m = MODE_LAND;
      ST_LOST:     m = MODE_HOLD;
      ST_FAILSAFE: m = MODE_FAILSAFE_LAND;
      default:     m = MODE_HOVER;
    endcase
    return m;
  endfunction

endpackage

[rtl/fms_decide.sv]
// Next-state rules of the mission supervisor for one sensor update.
// Depends on fms_pkg for the state, threshold and item types.
module fms_decide (
  input  fms_pkg::fms_item_t  item,
  input  fms_pkg::fms_state_t cur,
  input  fms_pkg::fms_cfg_t   cfg,
  output fms_pkg::fms_state_t nxt
);
  import fms_pkg::*;

  logic [31:0] hs2;
  logic [31:0] unseen_ms;
  logic [31:0] landing_ms;
  logic [31:0] start_ms;
  logic        land_suspect;
  logic        start_cue;
  logic        hovering;
  mission_t    target;

  // Squared horizontal speed and the elapsed times, with wrapping subtraction.
  assign hs2 = item.sq_x + item.sq_y;
  assign unseen_ms = item.now_ms - cur.last_seen_time;
  assign landing_ms = cur.landing_pending ? (item.now_ms - cur.landing_time) : 32'd0;
  assign start_ms = cur.start_pending ? (item.now_ms - cur.start_time) : 32'd0;

  assign land_suspect = item.alt_valid &&
                        ($signed(item.altitude) < $signed(cfg.landing_alt_limit)) &&
                        ($signed(item.vz) < $signed(cfg.landing_vz_limit)) &&
                        (hs2 < {2'b00, cfg.landing_hs_sq});
  assign start_cue = hs2 > {2'b00, cfg.start_sq};
  assign hovering = hs2 < {2'b00, cfg.hover_sq};

  // Rules in priority order: visibility, covariance, landing, start, hover.
  always_comb begin
    nxt = cur;
    target = cur.mission;
    if (!item.sighted) begin
      nxt.start_pending = 1'b0;
      nxt.landing_pending = 1'b0;
      if (!cur.seen_once) begin
        target = ST_WAIT;
      end else if (unseen_ms < {16'd0, cfg.lost_hold_ms}) begin
        target = ST_LOST;
      end else begin
        target = ST_FAILSAFE;
      end
    end else begin
      nxt.seen_once = 1'b1;
      nxt.last_seen_time = item.now_ms;
      if (item.cov_over) begin
        nxt.start_pending = 1'b0;
        nxt.landing_pending = 1'b0;
        target = ST_LOST;
      end else if (land_suspect) begin
        if (!cur.landing_pending) begin
          nxt.landing_pending = 1'b1;
          nxt.landing_time = item.now_ms;
        end
        target = (landing_ms >= {16'd0, cfg.landing_confirm_ms}) ? ST_LANDED : ST_LANDCAND;
      end else begin
        nxt.landing_pending = 1'b0;
        if (cur.mission == ST_WAIT || cur.mission == ST_READY) begin
          if (!start_cue) begin
            nxt.start_pending = 1'b0;
            target = ST_READY;
          end else begin
            if (!cur.start_pending) begin
              nxt.start_pending = 1'b1;
              nxt.start_time = item.now_ms;
            end
            target = (start_ms >= {16'd0, cfg.start_confirm_ms}) ? ST_FOLLOW : ST_READY;
          end
        end else if (cur.mission == ST_FOLLOW) begin
          target = hovering ? ST_HOVER : ST_FOLLOW;
        end else if (cur.mission == ST_HOVER) begin
          target = start_cue ? ST_FOLLOW : ST_HOVER;
        end else if (cur.followed_once &&
                     (cur.mission == ST_LOST || cur.mission == ST_LANDCAND)) begin
          target = start_cue ? ST_FOLLOW : ST_HOVER;
        end else begin
          target = ST_READY;
        end
      end
    end
    nxt.mission = target;
    if (target == ST_FOLLOW) begin
      nxt.followed_once = 1'b1;
    end
  end

endmodule

[rtl/follower_mission_supervisor.sv]
// Top level of the follower mission supervisor: streams, registers, pipeline.
// Depends on fms_pkg and fms_decide.
//
//  channel   direction  handshake                    contents
//  s_axis    in         s_axis_tvalid/s_axis_tready  one sensor update per request
//  m_axis    out        m_axis_tvalid/m_axis_tready  mission state and policy
//  cfg       in         cfg_valid/cfg_ready          register index and value
//
// One update per cycle is accepted while a stage is free; each result passes through
// the input register, the squaring stage, then the decision into the result register.
// The mission state updates as an update enters the result register.
// Reset is synchronous; no request is taken during it, and the pipeline empties.
// A stalled output holds its result; each stage keeps taking requests while
// a stage behind it is empty, so up to three updates are held in flight.
module follower_mission_supervisor (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // now_ms[31:0], sighted[32], alt_valid[33], altitude[49:34],
  // cov_trace[65:50], world_valid[66], world_velocity[114:67], body_valid[115],
  // body_velocity[163:116], rel_valid[164], rel_velocity[212:165], zero fill
  input  logic [fms_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // mission_state[2:0], control_mode[5:3], track_leader[6], commit_landing[7]
  output logic [fms_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fms_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [fms_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import fms_pkg::*;

  // Configuration registers.
  logic [15:0] lost_hold_ms;
  logic [15:0] landing_alt_limit;
  logic [15:0] landing_vz_limit;
  logic [14:0] landing_hspeed_limit;
  logic [15:0] landing_confirm_ms;
  logic [14:0] start_speed_limit;
  logic [15:0] start_confirm_ms;
  logic [14:0] hover_speed_limit;
  logic [29:0] landing_hs_sq;
  logic [29:0] start_sq;
  logic [29:0] hover_sq;
  fms_cfg_t    cfg;

  // Pipeline stages.
  logic               v1;
  logic               v2;
  logic               r1;
  logic               r2;
  logic               o_ready;
  logic               advance;
  logic [31:0]        s1_now;
  logic               s1_visible;
  logic               s1_alt_valid;
  logic signed [15:0] s1_alt;
  logic               s1_cov_over;
  logic signed [15:0] s1_vx;
  logic signed [15:0] s1_vy;
  logic signed [15:0] s1_vz;
  fms_item_t          s2;
  logic [47:0]        vel_sel;
  logic               vel_ok;

  fms_state_t st;
  fms_state_t st_next;
  mode_t      mode_next;

  assign cfg_ready = !rst;

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      lost_hold_ms <= RST_LOST_HOLD_MS;
      landing_alt_limit <= RST_LANDING_ALT_LIMIT;
      landing_vz_limit <= RST_LANDING_VZ_LIMIT;
      landing_hspeed_limit <= RST_LANDING_HSPEED_LIMIT;
      landing_confirm_ms <= RST_LANDING_CONFIRM_MS;
      start_speed_limit <= RST_START_SPEED_LIMIT;
      start_confirm_ms <= RST_START_CONFIRM_MS;
      hover_speed_limit <= RST_HOVER_SPEED_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOST_HOLD_MS:         lost_hold_ms <= cfg_data;
        REG_LANDING_ALT_LIMIT:    landing_alt_limit <= cfg_data;
        REG_LANDING_VZ_LIMIT:     landing_vz_limit <= cfg_data;
        REG_LANDING_HSPEED_LIMIT: landing_hspeed_limit <= cfg_data[14:0];
        REG_LANDING_CONFIRM_MS:   landing_confirm_ms <= cfg_data;
        REG_START_SPEED_LIMIT:    start_speed_limit <= cfg_data[14:0];
        REG_START_CONFIRM_MS:     start_confirm_ms <= cfg_data;
        REG_HOVER_SPEED_LIMIT:    hover_speed_limit <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // Squared speed limits, refreshed every cycle from the registers.
  always_ff @(posedge clk) begin
    landing_hs_sq <= 30'(landing_hspeed_limit) * 30'(landing_hspeed_limit);
    start_sq <= 30'(start_speed_limit) * 30'(start_speed_limit);
    hover_sq <= 30'(hover_speed_limit) * 30'(hover_speed_limit);
  end

  always_comb begin
    cfg.lost_hold_ms = lost_hold_ms;
    cfg.landing_alt_limit = landing_alt_limit;
    cfg.landing_vz_limit = landing_vz_limit;
    cfg.landing_hs_sq = landing_hs_sq;
    cfg.landing_confirm_ms = landing_confirm_ms;
    cfg.start_sq = start_sq;
    cfg.start_confirm_ms = start_confirm_ms;
    cfg.hover_sq = hover_sq;
  end

  // Stage handshakes: each stage loads when it is empty or moves on.
  assign o_ready = !m_axis_tvalid || m_axis_tready;
  assign r2 = !v2 || o_ready;
  assign r1 = !v1 || r2;
  assign s_axis_tready = r1 && !rst;
  assign advance = v2 && o_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (r1) begin
        v1 <= s_axis_tvalid;
      end
      if (r2) begin
        v2 <= v1;
      end
      if (o_ready) begin
        m_axis_tvalid <= v2;
      end
    end
  end

  // First velocity present, in the order world, body, relative.
  always_comb begin
    vel_ok = 1'b1;
    if (s_axis_tdata[66]) begin
      vel_sel = s_axis_tdata[114:67];
    end else if (s_axis_tdata[115]) begin
      vel_sel = s_axis_tdata[163:116];
    end else if (s_axis_tdata[164]) begin
      vel_sel = s_axis_tdata[212:165];
    end else begin
      vel_sel = 48'd0;
      vel_ok = 1'b0;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (r1) begin
      s1_now <= s_axis_tdata[31:0];
      s1_visible <= s_axis_tdata[32];
      s1_alt_valid <= s_axis_tdata[33];
      s1_alt <= s_axis_tdata[49:34];
      s1_cov_over <= s_axis_tdata[65:50] > COV_LIMIT;
      s1_vx <= vel_ok ? vel_sel[15:0] : 16'sd0;
      s1_vy <= vel_ok ? vel_sel[31:16] : 16'sd0;
      s1_vz <= vel_ok ? vel_sel[47:32] : 16'sd0;
    end
  end

  // Squaring stage; the full 32-bit square of each signed component is kept.
  always_ff @(posedge clk) begin
    if (r2) begin
      s2.now_ms <= s1_now;
      s2.sighted <= s1_visible;
      s2.alt_valid <= s1_alt_valid;
      s2.altitude <= s1_alt;
      s2.cov_over <= s1_cov_over;
      s2.vz <= s1_vz;
      s2.sq_x <= 32'(s1_vx) * 32'(s1_vx);
      s2.sq_y <= 32'(s1_vy) * 32'(s1_vy);
    end
  end

  fms_decide u_decide (
    .item (s2),
    .cur  (st),
    .cfg  (cfg),
    .nxt  (st_next)
  );

  assign mode_next = mode_of(st_next.mission);

  // Mission state, updated once per update that enters the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {
        (st_next.mission == ST_LANDED) || (st_next.mission == ST_FAILSAFE),
        (st_next.mission == ST_FOLLOW) || (st_next.mission == ST_HOVER),
        mode_next,
        st_next.mission
      };
    end
  end

  // The input side only stalls when all three stages hold an update.
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (v1 && v2 && m_axis_tvalid))
    else $error("input stalled with a free stage");

  // An update leaving the squaring stage shows up as a result.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_axis_tvalid)
    else $error("update lost between decision and result");

  // Without any sighting so far, a hidden leader keeps the block waiting.
  a_wait_unseen: assert property (@(posedge clk) disable iff (rst)
    (advance && !s2.sighted && !st.seen_once) |=>
      (m_axis_tdata[2:0] == ST_WAIT))
    else $error("left wait before the leader was seen");

  // Following implies the has-followed flag is set, and it never clears.
  a_follow_flag: assert property (@(posedge clk) disable iff (rst)
    (st.mission == ST_FOLLOW) |-> st.followed_once)
    else $error("follow state without has-followed flag");

  a_flag_sticky: assert property (@(posedge clk) disable iff (rst)
    st.followed_once |=> st.followed_once)
    else $error("has-followed flag cleared");

endmodule

[dv/testbench.sv]
// Self-checking testbench for follower_mission_supervisor: drives sensor updates and
// register writes, predicts every mission result and compares it field by field.
// Depends on fms_pkg and the RTL of follower_mission_supervisor.
module testbench;
  import fms_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 9;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int FLOOD_CYCLES = 300;

  // Register indexes that decode to no register.
  localparam logic [CFG_INDEX_W-1:0] IDX_UNUSED_LO = 8'd8;
  localparam logic [CFG_INDEX_W-1:0] IDX_UNUSED_HI = 8'hFF;

  // Which velocity vector carries the leader speed.
  localparam int SRC_WORLD = 0;
  localparam int SRC_BODY = 1;
  localparam int SRC_REL = 2;
  localparam int SRC_NONE = 3;

  // Kinds of update runs in the random part.
  localparam int K_CRUISE = 0;
  localparam int K_HOVER = 1;
  localparam int K_LAND = 2;
  localparam int K_UNSEEN = 3;
  localparam int K_COV = 4;
  localparam int K_NOISE = 5;

  // One sensor update, last field in the lowest bits as on s_axis_tdata.
  typedef struct packed {
    logic [47:0]        rel_velocity;
    logic               rel_valid;
    logic [47:0]        body_velocity;
    logic               body_valid;
    logic [47:0]        world_velocity;
    logic               world_valid;
    logic [15:0]        cov_trace;
    logic signed [15:0] altitude;
    logic               alt_valid;
    logic               sighted;
    logic [31:0]        now_ms;
  } update_t;

  // One result as carried on m_axis_tdata.
  typedef struct packed {
    logic     commit_landing;
    logic     track_leader;
    mode_t    control_mode;
    mission_t mission_state;
  } result_t;

  // Mission model with its own copy of the limits and the timers, and the
  // queue of results still owed by the block.
  class mission_scoreboard;
    logic [15:0]        lost_hold_ms;
    logic signed [15:0] alt_limit;
    logic signed [15:0] vz_limit;
    logic [14:0]        land_hs_limit;
    logic [15:0]        land_confirm_ms;
    logic [14:0]        start_limit;
    logic [15:0]        start_confirm_ms;
    logic [14:0]        hover_limit;

    mission_t    mission;
    bit          seen_once;
    logic [31:0] last_seen;
    bit          start_pending;
    logic [31:0] start_t;
    bit          land_pending;
    logic [31:0] land_t;
    bit          followed;

    result_t expected_q[$];
    int      errors;

    function new();
      lost_hold_ms = RST_LOST_HOLD_MS;
      alt_limit = RST_LANDING_ALT_LIMIT;
      vz_limit = RST_LANDING_VZ_LIMIT;
      land_hs_limit = RST_LANDING_HSPEED_LIMIT;
      land_confirm_ms = RST_LANDING_CONFIRM_MS;
      start_limit = RST_START_SPEED_LIMIT;
      start_confirm_ms = RST_START_CONFIRM_MS;
      hover_limit = RST_HOVER_SPEED_LIMIT;
      mission = ST_WAIT;
      seen_once = 0;
      last_seen = '0;
      start_pending = 0;
      start_t = '0;
      land_pending = 0;
      land_t = '0;
      followed = 0;
      errors = 0;
    endfunction

    // Speed limits keep only their low 15 bits; unknown indexes change nothing.
    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [15:0] val);
      case (idx)
        REG_LOST_HOLD_MS:         lost_hold_ms = val;
        REG_LANDING_ALT_LIMIT:    alt_limit = val;
        REG_LANDING_VZ_LIMIT:     vz_limit = val;
        REG_LANDING_HSPEED_LIMIT: land_hs_limit = val[14:0];
        REG_LANDING_CONFIRM_MS:   land_confirm_ms = val;
        REG_START_SPEED_LIMIT:    start_limit = val[14:0];
        REG_START_CONFIRM_MS:     start_confirm_ms = val;
        REG_HOVER_SPEED_LIMIT:    hover_limit = val[14:0];
        default: ;
      endcase
    endfunction

    function mission_t enter(mission_t s);
      mission = s;
      if (s == ST_FOLLOW) followed = 1;
      return s;
    endfunction

    // Next mission state for one update: visibility and lost hold first, then
    // covariance, landing, start and hover rules.
    function mission_t advance(update_t u);
      logic [47:0] v;
      logic [31:0] elapsed;
      longint      vx, vy, hs2;
      int          vz, alt;
      bit          have_v, land_suspect, start_cue;
      hs2 = 0;
      vz = 0;
      if (!u.sighted) begin
        start_pending = 0;
        land_pending = 0;
        if (!seen_once) return enter(ST_WAIT);
        elapsed = u.now_ms - last_seen;
        return enter(elapsed < {16'd0, lost_hold_ms} ? ST_LOST : ST_FAILSAFE);
      end
      seen_once = 1;
      last_seen = u.now_ms;

      // First vector present wins: world, then body, then relative.
      have_v = 1;
      v = '0;
      if (u.world_valid) v = u.world_velocity;
      else if (u.body_valid) v = u.body_velocity;
      else if (u.rel_valid) v = u.rel_velocity;
      else have_v = 0;
      if (have_v) begin
        vx = $signed(v[15:0]);
        vy = $signed(v[31:16]);
        vz = $signed(v[47:32]);
        hs2 = vx * vx + vy * vy;
      end

      if (u.cov_trace > COV_LIMIT) begin
        start_pending = 0;
        land_pending = 0;
        return enter(ST_LOST);
      end

      alt = $signed(u.altitude);
      land_suspect = u.alt_valid && alt < int'(alt_limit) && vz < int'(vz_limit) &&
                     hs2 < longint'(land_hs_limit) * longint'(land_hs_limit);
      if (land_suspect) begin
        if (!land_pending) begin
          land_pending = 1;
          land_t = u.now_ms;
        end
        elapsed = u.now_ms - land_t;
        return enter(elapsed >= {16'd0, land_confirm_ms} ? ST_LANDED : ST_LANDCAND);
      end
      land_pending = 0;

      start_cue = hs2 > longint'(start_limit) * longint'(start_limit);

      // Waiting for the leader to start moving.
      if (mission == ST_WAIT || mission == ST_READY) begin
        if (!start_cue) begin
          start_pending = 0;
          return enter(ST_READY);
        end
        if (!start_pending) begin
          start_pending = 1;
          start_t = u.now_ms;
        end
        elapsed = u.now_ms - start_t;
        return enter(elapsed >= {16'd0, start_confirm_ms} ? ST_FOLLOW : ST_READY);
      end

      // Following: drop to hover when slow, resume when started again.
      if (mission == ST_FOLLOW || mission == ST_HOVER) begin
        if (mission == ST_FOLLOW &&
            hs2 < longint'(hover_limit) * longint'(hover_limit))
          return enter(ST_HOVER);
        if (mission == ST_HOVER && start_cue) return enter(ST_FOLLOW);
        return enter(mission);
      end

      if (followed && (mission == ST_LOST || mission == ST_LANDCAND))
        return enter(start_cue ? ST_FOLLOW : ST_HOVER);
      return enter(ST_READY);
    endfunction

    // Called for every accepted update request.
    function void note_update(update_t u);
      result_t r;
      r.mission_state = advance(u);
      case (r.mission_state)
        ST_WAIT, ST_READY: r.control_mode = MODE_HOVER;
        ST_FOLLOW:         r.control_mode = MODE_FOLLOW;
        ST_HOVER:          r.control_mode = MODE_HOVER_TRACK;
        ST_LANDCAND:       r.control_mode = MODE_HOVER_CONFIRM;
        ST_LANDED:         r.control_mode = MODE_LAND;
        ST_LOST:           r.control_mode = MODE_HOLD;
        default:           r.control_mode = MODE_FAILSAFE_LAND;
      endcase
      r.track_leader = (r.mission_state == ST_FOLLOW || r.mission_state == ST_HOVER);
      r.commit_landing = (r.mission_state == ST_LANDED || r.mission_state == ST_FAILSAFE);
      expected_q.push_back(r);
    endfunction

    // Called for every accepted result request.
    function void check_result(logic [M_TDATA_W-1:0] data);
      result_t got, want;
      got = data;
      if (expected_q.size() == 0) begin
        $error("result %0h arrived with no update pending", data);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.mission_state !== want.mission_state) begin
        $error("mission_state: expected %0d, got %0d", want.mission_state, got.mission_state);
        errors++;
      end
      if (got.control_mode !== want.control_mode) begin
        $error("control_mode: expected %0d, got %0d", want.control_mode, got.control_mode);
        errors++;
      end
      if (got.track_leader !== want.track_leader) begin
        $error("track_leader: expected %0d, got %0d", want.track_leader, got.track_leader);
        errors++;
      end
      if (got.commit_landing !== want.commit_landing) begin
        $error("commit_landing: expected %0d, got %0d", want.commit_landing,
               got.commit_landing);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_axis_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  mission_scoreboard sb;
  int          cycles = 0;
  bit          send_calm = 0;
  bit          recv_calm = 0;
  bit          flood_req = 0;
  bit          flood_done = 0;
  logic [31:0] clock_ms = '0;

  follower_mission_supervisor dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  function automatic logic [47:0] rand48();
    return {$urandom, $urandom};
  endfunction

  // Random value of magnitude lo..hi with a random sign.
  function automatic int signed_mag(int lo, int hi);
    int m;
    m = $urandom_range(hi, lo);
    return $urandom_range(1, 0) ? -m : m;
  endfunction

  // Builds an update whose chosen vector carries vx, vy, vz; vectors of
  // lower priority get random content and random valid bits.
  function automatic update_t mk(logic [31:0] now, bit vis, logic [15:0] cov, int src,
                                 int vx, int vy, int vz, bit altv, int alt);
    update_t     u;
    logic [47:0] v;
    v = {vz[15:0], vy[15:0], vx[15:0]};
    u.now_ms = now;
    u.sighted = vis;
    u.alt_valid = altv;
    u.altitude = alt[15:0];
    u.cov_trace = cov;
    u.world_velocity = rand48();
    u.body_velocity = rand48();
    u.rel_velocity = rand48();
    u.world_valid = 0;
    u.body_valid = 0;
    u.rel_valid = 0;
    case (src)
      SRC_WORLD: begin
        u.world_valid = 1;
        u.world_velocity = v;
        u.body_valid = $urandom_range(1, 0);
        u.rel_valid = $urandom_range(1, 0);
      end
      SRC_BODY: begin
        u.body_valid = 1;
        u.body_velocity = v;
        u.rel_valid = $urandom_range(1, 0);
      end
      SRC_REL: begin
        u.rel_valid = 1;
        u.rel_velocity = v;
      end
      default: ;
    endcase
    return u;
  endfunction

  // Offers one update request after a random gap and waits for its acceptance.
  task automatic send_update(update_t u);
    int gap;
    gap = send_calm ? 0 : $urandom_range(9, 0);
    if ($urandom_range(19, 0) == 0) send_calm = !send_calm;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(S_TDATA_W - $bits(update_t)){1'b0}}, u};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_update(u);
  endtask

  task automatic drive_reg(logic [CFG_INDEX_W-1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  // Stops offering updates and waits until every result has come back.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Writes all limits: phase 1 the low extremes, phase 2 the high ones,
  // later phases moderate random values.
  task automatic set_limits(int p);
    int lh, al, vl, lhs, lc, ss, sc, hv;
    if (p == 1) begin
      lh = 0; al = -32768; vl = -32768; lhs = 0; lc = 0; ss = 0; sc = 0; hv = 0;
    end else if (p == 2) begin
      lh = 65535; al = 32767; vl = 32767; lhs = 65535; lc = 65535; ss = 65535;
      sc = 65535; hv = 65535;
    end else begin
      lh = $urandom_range(3000, 0);
      al = int'($urandom_range(800, 0)) - 200;
      vl = int'($urandom_range(300, 0)) - 100;
      lhs = $urandom_range(400, 0) | ($urandom_range(1, 0) << 15);
      lc = $urandom_range(4000, 0);
      ss = $urandom_range(600, 0) | ($urandom_range(1, 0) << 15);
      sc = $urandom_range(3000, 0);
      hv = $urandom_range(400, 0) | ($urandom_range(1, 0) << 15);
    end
    drive_reg(REG_LOST_HOLD_MS, 16'(lh));
    drive_reg(REG_LANDING_ALT_LIMIT, 16'(al));
    if (p <= 2) drive_reg(IDX_UNUSED_LO, 16'($urandom));
    drive_reg(REG_LANDING_VZ_LIMIT, 16'(vl));
    drive_reg(REG_LANDING_HSPEED_LIMIT, 16'(lhs));
    drive_reg(REG_LANDING_CONFIRM_MS, 16'(lc));
    drive_reg(REG_START_SPEED_LIMIT, 16'(ss));
    drive_reg(REG_START_CONFIRM_MS, 16'(sc));
    if (p <= 2) drive_reg(IDX_UNUSED_HI, 16'($urandom));
    drive_reg(REG_HOVER_SPEED_LIMIT, 16'(hv));
    cfg_valid <= 1'b0;
  endtask

  // Random flight: runs of one kind of update with time moving forward, so
  // that start, landing and lost-hold timers can run out; some pure noise.
  task automatic fly_random(int n);
    int       kind, left, r, step_max, s, h, lh, a, vz, src;
    update_t  u;
    logic [223:0] bits;
    left = 0;
    kind = K_CRUISE;
    step_max = sb.lost_hold_ms;
    if (sb.land_confirm_ms > step_max) step_max = sb.land_confirm_ms;
    if (sb.start_confirm_ms > step_max) step_max = sb.start_confirm_ms;
    step_max = step_max / 4 + 20;
    repeat (n) begin
      if (left == 0) begin
        r = $urandom_range(99, 0);
        kind = r < 25 ? K_CRUISE : r < 45 ? K_HOVER : r < 65 ? K_LAND :
               r < 77 ? K_UNSEEN : r < 85 ? K_COV : K_NOISE;
        left = $urandom_range(12, 1);
      end
      left--;
      clock_ms += $urandom_range(step_max, 0);
      s = sb.start_limit;
      s = s >= 32767 ? 32767 : s + 1;
      h = sb.hover_limit;
      lh = sb.land_hs_limit;
      a = sb.alt_limit;
      vz = sb.vz_limit;
      src = $urandom_range(SRC_REL, SRC_WORLD);
      case (kind)
        K_CRUISE:
          u = mk(clock_ms, 1, $urandom_range(2048, 0), src,
                 signed_mag(s, s + 600 > 32767 ? 32767 : s + 600),
                 int'($urandom_range(100, 0)) - 50, int'($urandom_range(600, 0)) - 300,
                 $urandom_range(1, 0), $urandom);
        K_HOVER:
          u = mk(clock_ms, 1, $urandom_range(2048, 0), $urandom_range(SRC_NONE, SRC_WORLD),
                 signed_mag(0, h / 2), signed_mag(0, h / 2),
                 int'($urandom_range(600, 0)) - 300, $urandom_range(1, 0),
                 a + 500 > 32767 ? 32767 : a + int'($urandom_range(500, 0)));
        K_LAND:
          u = mk(clock_ms, 1, $urandom_range(2048, 0), $urandom_range(SRC_NONE, SRC_WORLD),
                 signed_mag(0, lh / 2), signed_mag(0, lh / 2),
                 vz - 100 < -32768 ? -32768 : vz - int'($urandom_range(100, 1)), 1,
                 a - 300 < -32768 ? -32768 : a - int'($urandom_range(300, 1)));
        K_UNSEEN:
          u = mk(clock_ms, 0, $urandom, $urandom_range(SRC_NONE, SRC_WORLD),
                 $urandom, $urandom, $urandom, $urandom_range(1, 0), $urandom);
        K_COV:
          u = mk(clock_ms, 1, $urandom_range(65535, 2049), src,
                 signed_mag(0, s), signed_mag(0, 300), int'($urandom_range(600, 0)) - 300,
                 $urandom_range(1, 0), $urandom);
        default: begin
          // Every bit random, time included, so time may also run backwards.
          bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
          u = bits[$bits(update_t)-1:0];
          if ($urandom_range(1, 0)) u.now_ms = clock_ms - $urandom_range(5000, 0);
        end
      endcase
      send_update(u);
    end
  endtask

  // Result side: random stalls, calm stretches, and one long hold-off.
  initial begin
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      if (flood_req && !flood_done) begin
        flood_done = 1;
        stall = FLOOD_CYCLES;
      end else begin
        stall = recv_calm ? 0 : $urandom_range(9, 0);
      end
      if ($urandom_range(19, 0) == 0) recv_calm = !recv_calm;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata);
    end
  end

  // Update side and run control.
  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed walk through the mission under the reset limits.
    send_update(mk(0, 0, 0, SRC_NONE, 0, 0, 0, 0, 0));            // unseen before first sight
    send_update(mk(10, 1, 0, SRC_NONE, 0, 0, 0, 0, 0));           // no velocity at all
    send_update(mk(20, 1, 2048, SRC_WORLD, 32767, 0, 0, 0, 0));   // covariance just at limit
    send_update(mk(1020, 1, 100, SRC_BODY, -32768, -32768, 32767, 1, 32767));
    send_update(mk(1100, 1, 0, SRC_REL, 10, 10, 0, 0, 0));
    send_update(mk(1200, 1, 0, SRC_WORLD, 200, 0, 0, 0, 0));
    send_update(mk(1300, 1, 2049, SRC_WORLD, 200, 0, 0, 0, 0));   // covariance over limit
    send_update(mk(1400, 1, 0, SRC_WORLD, 200, 0, 0, 0, 0));
    send_update(mk(1500, 1, 0, SRC_NONE, 0, 0, 0, 1, 127));       // landing suspected
    send_update(mk(3499, 1, 0, SRC_NONE, 0, 0, 0, 1, 127));
    send_update(mk(3500, 1, 0, SRC_NONE, 0, 0, 0, 1, 127));
    send_update(mk(3600, 0, 0, SRC_NONE, 0, 0, 0, 0, 0));
    send_update(mk(4500, 0, 0, SRC_NONE, 0, 0, 0, 0, 0));         // lost hold runs out
    send_update(mk(4600, 1, 0, SRC_WORLD, 60, 0, 0, 1, 128));
    send_update(mk(4601, 1, 0, SRC_WORLD, 0, 0, 51, 1, 0));
    send_update(mk(4000, 0, 0, SRC_NONE, 0, 0, 0, 0, 0));         // time runs backwards
    send_update('1);
    send_update('0);
    send_update(mk(5, 1, 0, SRC_WORLD, 129, 0, 0, 0, 0));
    send_update(mk(6, 1, 0, SRC_WORLD, 51, 0, 0, 0, 0));
    send_update(mk(7, 1, 0, SRC_WORLD, 50, 0, 0, 0, 0));
    send_update(mk(8, 1, 0, SRC_WORLD, 128, 0, 0, 0, 0));
    send_update(mk(9, 1, 0, SRC_WORLD, 0, 0, 0, 1, -32768));
    send_update(mk(10, 1, 0, SRC_NONE, 0, 0, 0, 0, 0));
    clock_ms = 32'd20000;

    // Random phases, each under its own set of limits.
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        wait_idle();
        set_limits(p);
      end
      if (p == 3) clock_ms = 32'hFFFF_F000;
      if (p == 2) flood_req = 1;
      fly_random(ITEMS_PER_PHASE);
    end

    wait_idle();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
